/* rtl/bspe_pkg.sv */
// bspe_pkg: shared widths, types and helpers of the surface point evaluator
// no dependencies
`timescale 1ns / 1ps

package bspe_pkg;

    localparam int MAX_ROWS   = 8;
    localparam int MAX_COLS   = 8;
    localparam int ROW_W      = $clog2(MAX_ROWS);
    localparam int COL_W      = $clog2(MAX_COLS);
    localparam int ADDR_W     = ROW_W + COL_W;
    localparam int DEPTH      = MAX_ROWS * MAX_COLS;
    localparam int LINE_N     = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
    localparam int LINE_W     = $clog2(LINE_N);
    localparam int COORD_W    = 32;
    localparam int PARAM_W    = 17;
    localparam int CNT_W      = 4;
    localparam int WGT_W      = 32;
    localparam int ROWPT_W    = 40;
    localparam int ACC_W      = 72;
    localparam int FACC_W     = 80;

    localparam logic [PARAM_W-1:0] ONE_Q16 = PARAM_W'(65536);
    localparam logic [WGT_W-1:0]   ONE_Q30 = WGT_W'(32'h4000_0000);

    localparam logic       REQ_LOAD = 1'b0;
    localparam logic       REQ_EVAL = 1'b1;
    localparam logic [0:0] REG_ROW_COUNT = 1'd0;
    localparam logic [0:0] REG_COL_COUNT = 1'd1;

    typedef struct packed {
        logic [COORD_W-1:0] val;
        logic               clip;
    } sat_t;

    function automatic logic [PARAM_W-1:0] clamp_param(input logic [PARAM_W-1:0] p);
        return (p > ONE_Q16) ? ONE_Q16 : p;
    endfunction

    function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] n,
                                                      input logic [CNT_W-1:0] mx);
        logic [CNT_W-1:0] r;
        r = n;
        if (n == '0)
            r = CNT_W'(1);
        else if (n > mx)
            r = mx;
        return r;
    endfunction

    // round half up, shift by 30, clip to int32
    function automatic sat_t sat32(input logic signed [FACC_W-1:0] s);
        logic signed [FACC_W-1:0] r;
        sat_t o;
        r = (s + FACC_W'(64'sh2000_0000)) >>> 30;
        o.clip = 1'b0;
        o.val  = r[COORD_W-1:0];
        if (r > FACC_W'(64'sh7FFF_FFFF)) begin
            o.val  = 32'h7FFF_FFFF;
            o.clip = 1'b1;
        end else if (r < -FACC_W'(64'sh8000_0000)) begin
            o.val  = 32'h8000_0000;
            o.clip = 1'b1;
        end
        return o;
    endfunction

endpackage

/* rtl/bspe_if.sv */
// bspe_in_if / bspe_out_if: valid-ready channels of the evaluator
// depends on bspe_pkg
`timescale 1ns / 1ps

interface bspe_in_if;
    import bspe_pkg::*;
    logic                      valid;
    logic                      ready;
    logic                      req_type;
    logic [ROW_W-1:0]          row_index;
    logic [COL_W-1:0]          col_index;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
    logic [PARAM_W-1:0]        param_u;
    logic [PARAM_W-1:0]        param_v;

    modport source (output valid, req_type, row_index, col_index, coord_x, coord_y,
                    coord_z, param_u, param_v, input ready);
    modport sink   (input valid, req_type, row_index, col_index, coord_x, coord_y,
                    coord_z, param_u, param_v, output ready);
endinterface

interface bspe_out_if;
    import bspe_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
    logic                      saturated;

    modport source (output valid, point_x, point_y, point_z, saturated, input ready);
    modport sink   (input valid, point_x, point_y, point_z, saturated, output ready);
endinterface

/* rtl/bezier_surface_point_eval_core.sv */
// bezier_surface_point_eval_core: tensor-product bezier surface point evaluator
// depends on bspe_pkg and the channel interfaces in bspe_if.sv
//
//  channel  dir  payload                                   accepted when
//  in_ch    in   req_type, indexes, coords, param_u/v      valid && ready
//  out_ch   out  point_x/y/z, saturated                    valid && ready
//  cfg      in   cfg_index, cfg_data (row/col count)       cfg_we
//
// a load is written straight into the control store when accepted. an evaluation
// first raises the weights (one weight per cycle per parameter, rotating weight
// line), then streams the nr*nc store reads through the multiply-accumulate pipe,
// then runs the final reduction over the nr row points.
// in_ch.ready is high only in idle; a finished result waits in the output
// register while loads go on. reset clears control state and the counts to 4.
`timescale 1ns / 1ps

module bezier_surface_point_eval_core
    import bspe_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    bspe_in_if.sink          in_ch,
    bspe_out_if.source       out_ch,
    input  logic             cfg_we,
    input  logic [0:0]       cfg_index,
    input  logic [CNT_W-1:0] cfg_data
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_WGT  = 5'b00010,
        ST_MAC  = 5'b00100,
        ST_FIN  = 5'b01000,
        ST_SAT  = 5'b10000
    } state_t;

    state_t state_reg;

    logic [CNT_W-1:0] row_count_reg, col_count_reg;
    logic [CNT_W-1:0] nr_reg, nc_reg;

    // control store
    logic [3*COORD_W-1:0] mem [DEPTH];
    logic [3*COORD_W-1:0] mem_q_reg;
    logic [ADDR_W-1:0]    rd_addr;

    // weight lines
    logic [WGT_W-1:0]   wu_reg [LINE_N];
    logic [WGT_W-1:0]   wv_reg [LINE_N];
    logic [PARAM_W-1:0] tu_reg, su_reg, tv_reg, sv_reg;
    logic [LINE_W-1:0]  k_reg, i_reg;
    logic [CNT_W-1:0]   maxn;
    logic [WGT_W-1:0]   wu_new, wv_new;

    // mac pipe
    logic [ROW_W-1:0] r_reg, r1_reg, r2_reg;
    logic [COL_W-1:0] c_reg, c1_reg;
    logic             iss_reg, v1_reg, v2_reg, lr1_reg, lr2_reg;
    logic signed [2*COORD_W:0] px_reg, py_reg, pz_reg;
    logic signed [ACC_W-1:0]   ax_reg, ay_reg, az_reg;
    logic signed [ACC_W-1:0]   sx, sy, sz, rx, ry, rz;
    logic signed [ROWPT_W-1:0] rpx_reg [MAX_ROWS];
    logic signed [ROWPT_W-1:0] rpy_reg [MAX_ROWS];
    logic signed [ROWPT_W-1:0] rpz_reg [MAX_ROWS];

    // final reduction
    logic [ROW_W-1:0] f_reg;
    logic             fiss_reg, va_reg, vb_reg, la_reg, lb_reg;
    logic signed [ROWPT_W+WGT_W:0] fx_reg, fy_reg, fz_reg;
    logic signed [FACC_W-1:0]      gx_reg, gy_reg, gz_reg;
    sat_t ox, oy, oz;

    logic out_load;

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign maxn = (nr_reg > nc_reg) ? nr_reg : nc_reg;

    // weight raise: w[i] = (w[i]*s + w[i-1]*t + half) >> 16, top of line is w[i]
    function automatic logic [WGT_W-1:0] raise(input logic [WGT_W-1:0] a,
                                               input logic [WGT_W-1:0] b,
                                               input logic [PARAM_W-1:0] s,
                                               input logic [PARAM_W-1:0] t,
                                               input logic use_b);
        logic [WGT_W+PARAM_W:0] acc;
        acc = (WGT_W+PARAM_W+1)'(a) * (WGT_W+PARAM_W+1)'(s) + (WGT_W+PARAM_W+1)'(32768);
        if (use_b)
            acc = acc + (WGT_W+PARAM_W+1)'(b) * (WGT_W+PARAM_W+1)'(t);
        return acc[WGT_W+15:16];
    endfunction

    always_comb
    begin
        wu_new = raise(wu_reg[LINE_N-1], wu_reg[LINE_N-2], su_reg, tu_reg, i_reg != '0);
        wv_new = raise(wv_reg[LINE_N-1], wv_reg[LINE_N-2], sv_reg, tv_reg, i_reg != '0);
        if (i_reg > k_reg)
        begin
            wu_new = '0;
            wv_new = '0;
        end
        // a line already at its degree just rotates
        if ({1'b0, k_reg} >= nc_reg)
            wu_new = wu_reg[LINE_N-1];
        if ({1'b0, k_reg} >= nr_reg)
            wv_new = wv_reg[LINE_N-1];
    end

    assign rd_addr = {r_reg, c_reg};

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_ch.valid && in_ch.req_type == REQ_LOAD)
            mem[{in_ch.row_index, in_ch.col_index}] <= {in_ch.coord_x, in_ch.coord_y,
                                                        in_ch.coord_z};
        if (iss_reg)
            mem_q_reg <= mem[rd_addr];
    end

    always_comb
    begin
        sx = ax_reg + ACC_W'(px_reg);
        sy = ay_reg + ACC_W'(py_reg);
        sz = az_reg + ACC_W'(pz_reg);
        rx = (sx + ACC_W'(64'sh2000_0000)) >>> 30;
        ry = (sy + ACC_W'(64'sh2000_0000)) >>> 30;
        rz = (sz + ACC_W'(64'sh2000_0000)) >>> 30;
        ox = sat32(gx_reg);
        oy = sat32(gy_reg);
        oz = sat32(gz_reg);
    end

    assign out_load = (state_reg == ST_SAT) && (!out_ch.valid || out_ch.ready);

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            row_count_reg <= CNT_W'(4);
            col_count_reg <= CNT_W'(4);
            iss_reg       <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            fiss_reg      <= 1'b0;
            va_reg        <= 1'b0;
            vb_reg        <= 1'b0;
            out_ch.valid  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_ROW_COUNT: row_count_reg <= cfg_data;
                    REG_COL_COUNT: col_count_reg <= cfg_data;
                    default:       ;
                endcase
            end

            v1_reg <= iss_reg;
            v2_reg <= v1_reg;
            va_reg <= fiss_reg;
            vb_reg <= va_reg;

            if (out_load)
                out_ch.valid <= 1'b1;
            else if (out_ch.ready)
                out_ch.valid <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_ch.valid && in_ch.req_type == REQ_EVAL)
                        state_reg <= ST_WGT;
                end
                ST_WGT:
                begin
                    if (maxn == CNT_W'(1) ||
                        (i_reg == '0 && {1'b0, k_reg} == maxn - CNT_W'(1)))
                    begin
                        state_reg <= ST_MAC;
                        iss_reg   <= 1'b1;
                    end
                end
                ST_MAC:
                begin
                    if (iss_reg && {1'b0, c_reg} == nc_reg - CNT_W'(1) &&
                        {1'b0, r_reg} == nr_reg - CNT_W'(1))
                        iss_reg <= 1'b0;
                    if (!iss_reg && !v1_reg && !v2_reg)
                    begin
                        state_reg <= ST_FIN;
                        fiss_reg  <= 1'b1;
                    end
                end
                ST_FIN:
                begin
                    if (fiss_reg && {1'b0, f_reg} == nr_reg - CNT_W'(1))
                        fiss_reg <= 1'b0;
                    if (vb_reg && lb_reg)
                        state_reg <= ST_SAT;
                end
                ST_SAT:
                begin
                    if (out_load)
                        state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                nr_reg <= clamp_count(row_count_reg, CNT_W'(MAX_ROWS));
                nc_reg <= clamp_count(col_count_reg, CNT_W'(MAX_COLS));
                tu_reg <= clamp_param(in_ch.param_u);
                su_reg <= ONE_Q16 - clamp_param(in_ch.param_u);
                tv_reg <= clamp_param(in_ch.param_v);
                sv_reg <= ONE_Q16 - clamp_param(in_ch.param_v);
                for (int j = 0; j < LINE_N; j++)
                begin
                    wu_reg[j] <= (j == 0) ? ONE_Q30 : '0;
                    wv_reg[j] <= (j == 0) ? ONE_Q30 : '0;
                end
                k_reg <= LINE_W'(1);
                i_reg <= LINE_W'(LINE_N - 1);
                r_reg <= '0;
                c_reg <= '0;
                f_reg <= '0;
                ax_reg <= '0;
                ay_reg <= '0;
                az_reg <= '0;
                gx_reg <= '0;
                gy_reg <= '0;
                gz_reg <= '0;
            end
            ST_WGT:
            begin
                if (maxn != CNT_W'(1))
                begin
                    // rotate up, new weight enters at the bottom
                    for (int j = LINE_N - 1; j > 0; j--)
                    begin
                        wu_reg[j] <= wu_reg[j-1];
                        wv_reg[j] <= wv_reg[j-1];
                    end
                    wu_reg[0] <= wu_new;
                    wv_reg[0] <= wv_new;
                    i_reg <= i_reg - LINE_W'(1);
                    if (i_reg == '0)
                        k_reg <= k_reg + LINE_W'(1);
                end
            end
            ST_MAC:
            begin
                if (iss_reg)
                begin
                    c1_reg  <= c_reg;
                    r1_reg  <= r_reg;
                    lr1_reg <= ({1'b0, c_reg} == nc_reg - CNT_W'(1));
                    if ({1'b0, c_reg} == nc_reg - CNT_W'(1))
                    begin
                        c_reg <= '0;
                        r_reg <= r_reg + ROW_W'(1);
                    end
                    else
                        c_reg <= c_reg + COL_W'(1);
                end
                if (v1_reg)
                begin
                    px_reg <= $signed(mem_q_reg[3*COORD_W-1:2*COORD_W]) *
                              $signed({1'b0, wu_reg[c1_reg]});
                    py_reg <= $signed(mem_q_reg[2*COORD_W-1:COORD_W]) *
                              $signed({1'b0, wu_reg[c1_reg]});
                    pz_reg <= $signed(mem_q_reg[COORD_W-1:0]) *
                              $signed({1'b0, wu_reg[c1_reg]});
                    r2_reg  <= r1_reg;
                    lr2_reg <= lr1_reg;
                end
                if (v2_reg)
                begin
                    if (lr2_reg)
                    begin
                        rpx_reg[r2_reg] <= rx[ROWPT_W-1:0];
                        rpy_reg[r2_reg] <= ry[ROWPT_W-1:0];
                        rpz_reg[r2_reg] <= rz[ROWPT_W-1:0];
                        ax_reg <= '0;
                        ay_reg <= '0;
                        az_reg <= '0;
                    end
                    else
                    begin
                        ax_reg <= sx;
                        ay_reg <= sy;
                        az_reg <= sz;
                    end
                end
            end
            ST_FIN:
            begin
                if (fiss_reg)
                begin
                    fx_reg <= rpx_reg[f_reg] * $signed({1'b0, wv_reg[f_reg]});
                    fy_reg <= rpy_reg[f_reg] * $signed({1'b0, wv_reg[f_reg]});
                    fz_reg <= rpz_reg[f_reg] * $signed({1'b0, wv_reg[f_reg]});
                    la_reg <= ({1'b0, f_reg} == nr_reg - CNT_W'(1));
                    f_reg  <= f_reg + ROW_W'(1);
                end
                lb_reg <= la_reg;
                if (va_reg)
                begin
                    gx_reg <= gx_reg + FACC_W'(fx_reg);
                    gy_reg <= gy_reg + FACC_W'(fy_reg);
                    gz_reg <= gz_reg + FACC_W'(fz_reg);
                end
            end
            ST_SAT:
            begin
                if (out_load)
                begin
                    out_ch.point_x   <= ox.val;
                    out_ch.point_y   <= oy.val;
                    out_ch.point_z   <= oz.val;
                    out_ch.saturated <= ox.clip | oy.clip | oz.clip;
                end
            end
            default: ;
        endcase
    end

endmodule
